### rtl/sspr_pkg.sv
// shared types and constants for the servo status packet receiver
// depends on nothing; used by sspr_parser and servo_status_packet_receiver_core

package sspr_pkg;

   // most parameter bytes one packet may carry
   localparam int MAX_PARAMS = 16;
   localparam logic [7:0] MAX_PARAMS_BYTE = 8'(MAX_PARAMS);

   // framing constants
   localparam logic [7:0] HEADER_BYTE = 8'hFF;
   localparam logic [7:0] LEN_OVERHEAD = 8'd2;
   localparam logic [15:0] TIMEOUT_RESET = 16'd500;
   localparam logic [15:0] IDLE_MAX = 16'hFFFF;
   localparam logic [7:0] ERROR_RESET = 8'hFF;

   typedef enum logic [1:0] {
      CMD_ARM  = 2'd0,
      CMD_BYTE = 2'd1,
      CMD_TICK = 2'd2
   } sspr_cmd_type;

   typedef enum logic [2:0] {
      PH_DISARMED = 3'd0,
      PH_FF1      = 3'd1,
      PH_FF2      = 3'd2,
      PH_ID       = 3'd3,
      PH_LEN      = 3'd4,
      PH_ERR      = 3'd5,
      PH_PARAMS   = 3'd6,
      PH_CHK      = 3'd7
   } sspr_phase_type;

   typedef enum logic [2:0] {
      K_PARAM    = 3'd0,
      K_OK       = 3'd1,
      K_HEADER   = 3'd2,
      K_CHECKSUM = 3'd3,
      K_LENGTH   = 3'd4,
      K_TIMEOUT  = 3'd5
   } sspr_kind_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] rx_byte;
   } sspr_req_type;

   typedef struct packed {
      sspr_kind_type kind;
      logic [7:0]    param_byte;
      logic [7:0]    param_index;
      logic [7:0]    packet_id;
      logic [7:0]    packet_error;
      logic [7:0]    stored_error_out;
      logic          last;
   } sspr_rsp_type;

   // result of one transaction handed from the parser to the output register
   typedef struct packed {
      logic         valid;
      sspr_rsp_type data;
   } sspr_result_type;

endpackage

### rtl/sspr_parser.sv
// packet parser state and single-pass next-state logic for one transaction
// depends on sspr_pkg

module sspr_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  sspr_pkg::sspr_req_type   item,
   input  logic                     csr_wr_en,
   input  logic [15:0]              csr_wr_data,
   output sspr_pkg::sspr_result_type result
);

   sspr_pkg::sspr_phase_type phase_ff, phase_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  left_ff, left_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  id_ff, id_in;
   logic [7:0]  err_ff, err_in;
   logic [7:0]  kept_ff, kept_in;
   logic [15:0] idle_ff, idle_in;
   logic [15:0] timeout_ff;

   logic [15:0] idle_inc;
   logic [7:0]  sum_add;
   logic [7:0]  len_params;
   logic        emit;
   sspr_pkg::sspr_kind_type kind;
   logic [7:0]  pbyte;
   logic [7:0]  pidx;
   logic        is_last;

   // timeout register
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= sspr_pkg::TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         timeout_ff <= csr_wr_data;
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sspr_pkg::PH_DISARMED;
         sum_ff   <= '0;
         left_ff  <= '0;
         count_ff <= '0;
         id_ff    <= '0;
         err_ff   <= sspr_pkg::ERROR_RESET;
         kept_ff  <= '0;
         idle_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         sum_ff   <= sum_in;
         left_ff  <= left_in;
         count_ff <= count_in;
         id_ff    <= id_in;
         err_ff   <= err_in;
         kept_ff  <= kept_in;
         idle_ff  <= idle_in;
      end
   end

   assign idle_inc   = (idle_ff == sspr_pkg::IDLE_MAX) ? idle_ff : idle_ff + 16'd1;
   assign sum_add    = sum_ff + item.rx_byte;
   assign len_params = item.rx_byte - sspr_pkg::LEN_OVERHEAD;

   // next state and result for the transaction in the input register
   always_comb begin
      phase_in = phase_ff;
      sum_in   = sum_ff;
      left_in  = left_ff;
      count_in = count_ff;
      id_in    = id_ff;
      err_in   = err_ff;
      kept_in  = kept_ff;
      idle_in  = idle_ff;
      emit     = 1'b0;
      kind     = sspr_pkg::K_PARAM;
      pbyte    = '0;
      pidx     = '0;
      is_last  = 1'b0;

      if (fire) begin
         unique case (item.command)
            sspr_pkg::CMD_ARM: begin
               phase_in = sspr_pkg::PH_FF1;
               sum_in   = '0;
               left_in  = '0;
               count_in = '0;
               id_in    = '0;
               err_in   = sspr_pkg::ERROR_RESET;
               idle_in  = '0;
            end
            sspr_pkg::CMD_BYTE: begin
               if (phase_ff != sspr_pkg::PH_DISARMED) begin
                  idle_in = '0;
                  unique case (phase_ff)
                     sspr_pkg::PH_FF1, sspr_pkg::PH_FF2: begin
                        if (item.rx_byte != sspr_pkg::HEADER_BYTE) begin
                           phase_in = sspr_pkg::PH_DISARMED;
                           emit     = 1'b1;
                           kind     = sspr_pkg::K_HEADER;
                           is_last  = 1'b1;
                        end else if (phase_ff == sspr_pkg::PH_FF1) begin
                           phase_in = sspr_pkg::PH_FF2;
                        end else begin
                           sum_in   = '0;
                           phase_in = sspr_pkg::PH_ID;
                        end
                     end
                     sspr_pkg::PH_ID: begin
                        id_in    = item.rx_byte;
                        sum_in   = sum_add;
                        phase_in = sspr_pkg::PH_LEN;
                     end
                     sspr_pkg::PH_LEN: begin
                        sum_in = sum_add;
                        if (item.rx_byte < sspr_pkg::LEN_OVERHEAD ||
                            len_params > sspr_pkg::MAX_PARAMS_BYTE) begin
                           phase_in = sspr_pkg::PH_DISARMED;
                           emit     = 1'b1;
                           kind     = sspr_pkg::K_LENGTH;
                           is_last  = 1'b1;
                        end else begin
                           left_in  = len_params;
                           count_in = '0;
                           phase_in = sspr_pkg::PH_ERR;
                        end
                     end
                     sspr_pkg::PH_ERR: begin
                        err_in   = item.rx_byte;
                        sum_in   = sum_add;
                        phase_in = (left_ff == 8'd0) ? sspr_pkg::PH_CHK
                                                     : sspr_pkg::PH_PARAMS;
                     end
                     sspr_pkg::PH_PARAMS: begin
                        sum_in   = sum_add;
                        count_in = count_ff + 8'd1;
                        left_in  = left_ff - 8'd1;
                        if (left_ff == 8'd1) begin
                           phase_in = sspr_pkg::PH_CHK;
                        end
                        emit  = 1'b1;
                        kind  = sspr_pkg::K_PARAM;
                        pbyte = item.rx_byte;
                        pidx  = count_ff;
                     end
                     sspr_pkg::PH_CHK: begin
                        phase_in = sspr_pkg::PH_DISARMED;
                        emit     = 1'b1;
                        is_last  = 1'b1;
                        if (item.rx_byte == ~sum_ff) begin
                           kept_in = err_ff;
                           kind    = sspr_pkg::K_OK;
                        end else begin
                           kind = sspr_pkg::K_CHECKSUM;
                        end
                     end
                     default: begin
                        phase_in = phase_ff;
                     end
                  endcase
               end
            end
            sspr_pkg::CMD_TICK: begin
               if (phase_ff != sspr_pkg::PH_DISARMED) begin
                  idle_in = idle_inc;
                  if (idle_inc >= timeout_ff) begin
                     phase_in = sspr_pkg::PH_DISARMED;
                     emit     = 1'b1;
                     kind     = sspr_pkg::K_TIMEOUT;
                     is_last  = 1'b1;
                  end
               end
            end
            default: begin
               emit = 1'b0;
            end
         endcase
      end
   end

   // result fields carry the state as left by this transaction
   always_comb begin
      result.valid                 = emit;
      result.data.kind             = kind;
      result.data.param_byte       = pbyte;
      result.data.param_index      = pidx;
      result.data.packet_id        = id_in;
      result.data.packet_error     = err_in;
      result.data.stored_error_out = kept_in;
      result.data.last             = is_last;
   end

   // parameter bookkeeping never runs past the buffer size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff + left_ff) <= {1'b0, sspr_pkg::MAX_PARAMS_BYTE})
      else $error("parameter count plus remaining exceeds buffer size");

   // a disarmed receiver produces no result
   a_disarmed_quiet: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == sspr_pkg::PH_DISARMED) |-> !result.valid)
      else $error("result produced while disarmed");

   // a final status always leaves the receiver disarmed
   a_last_disarms: assert property (@(posedge clock) disable iff (reset)
      (result.valid && result.data.last) |=> (phase_ff == sspr_pkg::PH_DISARMED))
      else $error("receiver still armed after final status");

   // kept error only moves on a good packet
   a_kept_on_ok: assert property (@(posedge clock) disable iff (reset)
      (kept_ff != kept_in) |-> (result.valid && result.data.kind == sspr_pkg::K_OK))
      else $error("kept error changed without a good packet");

endmodule

### rtl/servo_status_packet_receiver_core.sv
// servo status packet receiver: input register, parser and output register
// depends on sspr_pkg and sspr_parser
// an accepted transaction is held in the input register and its result in the output register
// throughput: one transaction per cycle while rsp_stall holds no result, set by the single-pass parser stage
// the output register frees its slot in the same cycle it is taken, so no bubbles
// reset: synchronous active high; receiver disarmed, timeout 500 ticks, kept error 0

module servo_status_packet_receiver_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sspr_pkg::sspr_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sspr_pkg::sspr_rsp_type rsp_data,
   input  logic                   csr_wr_en,
   input  logic [15:0]            csr_wr_data
);

   logic                      in_valid_ff, in_valid_in;
   sspr_pkg::sspr_req_type    in_item_ff;
   logic                      out_valid_ff, out_valid_in;
   sspr_pkg::sspr_rsp_type    out_item_ff;
   logic                      fire;
   logic                      req_accept;
   sspr_pkg::sspr_result_type result;

   // the held transaction moves on when the output slot is free or draining
   assign fire       = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !fire;
   assign req_accept = req_valid && !req_stall;

   assign in_valid_in  = req_accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign out_valid_in = fire ? result.valid : (rsp_stall ? out_valid_ff : 1'b0);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff <= req_data;
      end
   end

   sspr_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .item        (in_item_ff),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .result      (result)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && result.valid) begin
         out_item_ff <= result.data;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

   // the input side only stalls while it holds a transaction
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("input stalled with empty input register");

   // a held result is never overwritten while stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |-> !fire)
      else $error("parser fired into a stalled output register");

   // a pending transaction never waits on a free output register
   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_valid_ff) |-> fire)
      else $error("transaction held while output register empty");

endmodule

### bench/tb_servo_status_packet_receiver_core.sv
// self-checking bench for servo_status_packet_receiver_core: directed and random packets
// depends on sspr_pkg and the receiver core rtl; predicts every transaction in-line

`timescale 1ns / 100ps

module tb_servo_status_packet_receiver_core;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 6;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_COUNT = 7;
   localparam int ITEMS_PER_PHASE = 50;
   localparam int MAX_REPORTS = 40;

   typedef enum {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_mode_type;

   typedef enum {
      PKT_OK,
      PKT_BAD_SUM,
      PKT_BAD_HEADER,
      PKT_BAD_LENGTH,
      PKT_TIMEOUT,
      PKT_RESTART,
      PKT_NOISE
   } packet_flavor_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   sspr_pkg::sspr_req_type req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   sspr_pkg::sspr_rsp_type rsp_data;
   logic                   csr_wr_en = 1'b0;
   logic [15:0]            csr_wr_data = '0;

   // stimulus and expected results
   sspr_pkg::sspr_req_type pending_items[$];
   sspr_pkg::sspr_rsp_type expected_results[$];
   int           item_total = 0;
   int           mismatch_count = 0;
   int           cycle_count = 0;
   logic         hold_request = 1'b0;

   // receiver model state
   sspr_pkg::sspr_phase_type rx_phase = sspr_pkg::PH_DISARMED;
   logic [7:0]     sum_acc = '0;
   logic [7:0]     params_remaining = '0;
   logic [7:0]     params_taken = '0;
   logic [7:0]     cur_id = '0;
   logic [7:0]     cur_error = sspr_pkg::ERROR_RESET;
   logic [7:0]     kept_error_copy = '0;
   logic [15:0]    ticks_idle = '0;
   logic [15:0]    timeout_limit = sspr_pkg::TIMEOUT_RESET;

   servo_status_packet_receiver_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      if (mismatch_count < MAX_REPORTS)
         $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got,
                  want);
      mismatch_count++;
   endtask

   // advance the receiver model by one accepted transaction
   task automatic predict_receiver(input sspr_pkg::sspr_req_type t);
      sspr_pkg::sspr_rsp_type  r;
      logic                    has_result;
      logic                    ends_packet;
      sspr_pkg::sspr_kind_type k;
      logic [7:0]              b;
      r = '0;
      has_result = 1'b0;
      ends_packet = 1'b0;
      k = sspr_pkg::K_PARAM;
      b = t.rx_byte;
      if (t.command == sspr_pkg::CMD_ARM) begin
         rx_phase = sspr_pkg::PH_FF1;
         sum_acc = '0;
         params_remaining = '0;
         params_taken = '0;
         cur_id = '0;
         cur_error = sspr_pkg::ERROR_RESET;
         ticks_idle = '0;
      end else if (rx_phase != sspr_pkg::PH_DISARMED && t.command == sspr_pkg::CMD_BYTE) begin
         ticks_idle = '0;
         case (rx_phase)
            sspr_pkg::PH_FF1: begin
               if (b != sspr_pkg::HEADER_BYTE) begin
                  k = sspr_pkg::K_HEADER;
                  ends_packet = 1'b1;
               end else
                  rx_phase = sspr_pkg::PH_FF2;
            end
            sspr_pkg::PH_FF2: begin
               if (b != sspr_pkg::HEADER_BYTE) begin
                  k = sspr_pkg::K_HEADER;
                  ends_packet = 1'b1;
               end else begin
                  sum_acc = '0;
                  rx_phase = sspr_pkg::PH_ID;
               end
            end
            sspr_pkg::PH_ID: begin
               cur_id = b;
               sum_acc = sum_acc + b;
               rx_phase = sspr_pkg::PH_LEN;
            end
            sspr_pkg::PH_LEN: begin
               sum_acc = sum_acc + b;
               if (b < sspr_pkg::LEN_OVERHEAD ||
                   (b - sspr_pkg::LEN_OVERHEAD) > sspr_pkg::MAX_PARAMS_BYTE) begin
                  k = sspr_pkg::K_LENGTH;
                  ends_packet = 1'b1;
               end else begin
                  params_remaining = b - sspr_pkg::LEN_OVERHEAD;
                  params_taken = '0;
                  rx_phase = sspr_pkg::PH_ERR;
               end
            end
            sspr_pkg::PH_ERR: begin
               cur_error = b;
               sum_acc = sum_acc + b;
               rx_phase = (params_remaining == 8'd0) ? sspr_pkg::PH_CHK
                                                     : sspr_pkg::PH_PARAMS;
            end
            sspr_pkg::PH_PARAMS: begin
               r.param_byte = b;
               r.param_index = params_taken;
               has_result = 1'b1;
               sum_acc = sum_acc + b;
               params_taken = params_taken + 8'd1;
               params_remaining = params_remaining - 8'd1;
               if (params_remaining == 8'd0)
                  rx_phase = sspr_pkg::PH_CHK;
            end
            sspr_pkg::PH_CHK: begin
               if (b == ~sum_acc) begin
                  kept_error_copy = cur_error;
                  k = sspr_pkg::K_OK;
               end else
                  k = sspr_pkg::K_CHECKSUM;
               ends_packet = 1'b1;
            end
            default: ;
         endcase
      end else if (rx_phase != sspr_pkg::PH_DISARMED && t.command == sspr_pkg::CMD_TICK) begin
         if (ticks_idle != sspr_pkg::IDLE_MAX)
            ticks_idle = ticks_idle + 16'd1;
         if (ticks_idle >= timeout_limit) begin
            k = sspr_pkg::K_TIMEOUT;
            ends_packet = 1'b1;
         end
      end
      if (ends_packet) begin
         rx_phase = sspr_pkg::PH_DISARMED;
         has_result = 1'b1;
         r.last = 1'b1;
      end
      if (has_result) begin
         r.kind = k;
         r.packet_id = cur_id;
         r.packet_error = cur_error;
         r.stored_error_out = kept_error_copy;
         expected_results.push_back(r);
      end
   endtask

   // sender: bursts with random gaps, payload held while stalled
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         if (req_valid && !req_stall)
            predict_receiver(req_data);
         if (req_valid && req_stall) begin
            // hold the stalled transaction
         end else if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            req_data <= pending_items.pop_front();
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else
               burst_left <= burst_left - 1;
         end else
            req_valid <= 1'b0;
      end
   end

   // receiver stall pattern, with one long hold-off on request
   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left = 0;
   int             hold_left = 0;
   logic           hold_taken = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_mode <= STALL_NONE;
         mode_left <= 0;
         hold_left <= 0;
         hold_taken <= 1'b0;
      end else if (hold_request && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= stall_mode_type'($urandom_range(0, 3));
            mode_left <= $urandom_range(20, 200);
         end else
            mode_left <= mode_left - 1;
         case (stall_mode)
            STALL_NONE:   rsp_stall <= 1'b0;
            STALL_LIGHT:  rsp_stall <= ($urandom_range(0, 99) < 30);
            STALL_HEAVY:  rsp_stall <= ($urandom_range(0, 99) < 70);
            STALL_TOGGLE: rsp_stall <= ~rsp_stall;
            default:      rsp_stall <= 1'b0;
         endcase
      end
   end

   // result checker
   always @(posedge clock) begin : check_results
      sspr_pkg::sspr_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0)
            report_mismatch("result with nothing expected, kind", 8'(rsp_data.kind), 8'h0);
         else begin
            want = expected_results.pop_front();
            if (rsp_data.kind != want.kind)
               report_mismatch("kind", 8'(rsp_data.kind), 8'(want.kind));
            if (rsp_data.param_byte != want.param_byte)
               report_mismatch("param_byte", rsp_data.param_byte, want.param_byte);
            if (rsp_data.param_index != want.param_index)
               report_mismatch("param_index", rsp_data.param_index, want.param_index);
            if (rsp_data.packet_id != want.packet_id)
               report_mismatch("packet_id", rsp_data.packet_id, want.packet_id);
            if (rsp_data.packet_error != want.packet_error)
               report_mismatch("packet_error", rsp_data.packet_error, want.packet_error);
            if (rsp_data.stored_error_out != want.stored_error_out)
               report_mismatch("stored_error_out", rsp_data.stored_error_out,
                               want.stored_error_out);
            if (rsp_data.last != want.last)
               report_mismatch("last", 8'(rsp_data.last), 8'(want.last));
         end
      end
   end

   task automatic queue_item(input logic [1:0] cmd, input logic [7:0] b);
      sspr_pkg::sspr_req_type t;
      t.command = cmd;
      t.rx_byte = b;
      pending_items.push_back(t);
      item_total++;
   endtask

   // a few ticks or an unused command between bytes, never enough to time out
   task automatic queue_filler();
      int r;
      int most;
      r = $urandom_range(0, 99);
      most = (timeout_limit > 4) ? 3 : int'(timeout_limit) - 1;
      if (r < 20 && timeout_limit >= 2)
         repeat ($urandom_range(1, most)) queue_item(sspr_pkg::CMD_TICK, 8'($urandom));
      else if (r < 25)
         queue_item(CMD_UNUSED, 8'($urandom));
   endtask

   // one random packet, mostly well formed
   task automatic queue_packet();
      packet_flavor_type flavor;
      logic [7:0]        frame [0:sspr_pkg::MAX_PARAMS+5];
      int                frame_len;
      int                n_params;
      int                cut;
      int                pos;
      int                r;
      logic [7:0]        sum;
      r = $urandom_range(0, 99);
      if (r < 60) flavor = PKT_OK;
      else if (r < 70) flavor = PKT_BAD_SUM;
      else if (r < 76) flavor = PKT_BAD_HEADER;
      else if (r < 83) flavor = PKT_BAD_LENGTH;
      else if (r < 89) flavor = PKT_TIMEOUT;
      else if (r < 95) flavor = PKT_RESTART;
      else flavor = PKT_NOISE;
      if (flavor == PKT_TIMEOUT && timeout_limit > 400)
         flavor = PKT_OK;

      // receiver is disarmed here, so these are dropped
      if (flavor == PKT_NOISE) begin
         repeat ($urandom_range(1, 4)) queue_item(2'($urandom_range(1, 3)), 8'($urandom));
         return;
      end

      queue_item(sspr_pkg::CMD_ARM, 8'($urandom));
      // partial packet abandoned by a second arm
      if (flavor == PKT_RESTART) begin
         pos = $urandom_range(1, 4);
         for (int i = 0; i < pos; i++)
            queue_item(sspr_pkg::CMD_BYTE, (i < 2) ? sspr_pkg::HEADER_BYTE : 8'($urandom));
         queue_item(sspr_pkg::CMD_ARM, 8'($urandom));
      end

      n_params = ($urandom_range(0, 3) == 0) ? sspr_pkg::MAX_PARAMS
                                             : $urandom_range(0, sspr_pkg::MAX_PARAMS);
      frame[0] = sspr_pkg::HEADER_BYTE;
      frame[1] = sspr_pkg::HEADER_BYTE;
      frame[2] = 8'($urandom);
      frame[3] = 8'(n_params) + sspr_pkg::LEN_OVERHEAD;
      frame[4] = 8'($urandom);
      sum = frame[2] + frame[3] + frame[4];
      for (int i = 0; i < n_params; i++) begin
         frame[5 + i] = 8'($urandom);
         sum = sum + frame[5 + i];
      end
      frame[5 + n_params] = ~sum;
      frame_len = 6 + n_params;

      case (flavor)
         PKT_BAD_SUM: frame[5 + n_params] = ~sum ^ 8'($urandom_range(1, 255));
         PKT_BAD_HEADER: begin
            pos = $urandom_range(0, 1);
            frame[pos] = 8'($urandom_range(0, 254));
            frame_len = pos + 1;
         end
         PKT_BAD_LENGTH: begin
            frame[3] = ($urandom_range(0, 1) == 0)
                       ? 8'($urandom_range(0, 1))
                       : 8'($urandom_range(sspr_pkg::MAX_PARAMS + 3, 255));
            frame_len = 4;
         end
         default: ;
      endcase

      cut = (flavor == PKT_TIMEOUT) ? $urandom_range(0, frame_len - 1) : frame_len;
      for (int i = 0; i < cut; i++) begin
         queue_filler();
         queue_item(sspr_pkg::CMD_BYTE, frame[i]);
      end
      if (flavor == PKT_TIMEOUT)
         repeat ((timeout_limit == 0) ? 1 : int'(timeout_limit))
            queue_item(sspr_pkg::CMD_TICK, 8'($urandom));
   endtask

   // sender pause: everything accepted and answered, then let the pipeline settle
   task automatic wait_until_drained();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_timeout(input logic [15:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      timeout_limit = value;
      @(negedge clock);
   endtask

   function automatic logic [15:0] timeout_for_phase(input int p);
      case (p)
         0:       return 16'd1;
         1:       return 16'd0;
         2:       return 16'hFFFF;
         3:       return 16'd2;
         4:       return 16'd40;
         5:       return 16'd7;
         default: return sspr_pkg::TIMEOUT_RESET;
      endcase
   endfunction

   initial begin : stimulus
      int phase_start;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ignored while disarmed
      queue_item(sspr_pkg::CMD_BYTE, 8'h00);
      queue_item(sspr_pkg::CMD_TICK, 8'hFF);
      queue_item(CMD_UNUSED, 8'h5A);
      // shortest packet, no parameters, error byte all ones
      queue_item(sspr_pkg::CMD_ARM, 8'h00);
      queue_item(sspr_pkg::CMD_BYTE, sspr_pkg::HEADER_BYTE);
      queue_item(sspr_pkg::CMD_BYTE, sspr_pkg::HEADER_BYTE);
      queue_item(sspr_pkg::CMD_BYTE, 8'h00);
      queue_item(sspr_pkg::CMD_BYTE, 8'h02);
      queue_item(sspr_pkg::CMD_BYTE, 8'hFF);
      queue_item(sspr_pkg::CMD_BYTE, 8'hFE);
      // two parameters with a tick and an unused command inside, bad checksum
      queue_item(sspr_pkg::CMD_ARM, 8'hFF);
      queue_item(sspr_pkg::CMD_BYTE, sspr_pkg::HEADER_BYTE);
      queue_item(sspr_pkg::CMD_BYTE, sspr_pkg::HEADER_BYTE);
      queue_item(sspr_pkg::CMD_BYTE, 8'hFF);
      queue_item(sspr_pkg::CMD_BYTE, 8'h04);
      queue_item(sspr_pkg::CMD_BYTE, 8'h00);
      queue_item(sspr_pkg::CMD_TICK, 8'h00);
      queue_item(sspr_pkg::CMD_BYTE, 8'hFF);
      queue_item(CMD_UNUSED, 8'hA5);
      queue_item(sspr_pkg::CMD_BYTE, 8'h00);
      queue_item(sspr_pkg::CMD_BYTE, 8'hFC);
      // bad first and second header bytes
      queue_item(sspr_pkg::CMD_ARM, 8'h00);
      queue_item(sspr_pkg::CMD_BYTE, 8'h00);
      queue_item(sspr_pkg::CMD_ARM, 8'h00);
      queue_item(sspr_pkg::CMD_BYTE, sspr_pkg::HEADER_BYTE);
      queue_item(sspr_pkg::CMD_BYTE, 8'h7F);
      // length too short, then too long for the buffer
      queue_item(sspr_pkg::CMD_ARM, 8'h00);
      queue_item(sspr_pkg::CMD_BYTE, sspr_pkg::HEADER_BYTE);
      queue_item(sspr_pkg::CMD_BYTE, sspr_pkg::HEADER_BYTE);
      queue_item(sspr_pkg::CMD_BYTE, 8'h12);
      queue_item(sspr_pkg::CMD_BYTE, 8'h01);
      queue_item(sspr_pkg::CMD_ARM, 8'h00);
      queue_item(sspr_pkg::CMD_BYTE, sspr_pkg::HEADER_BYTE);
      queue_item(sspr_pkg::CMD_BYTE, sspr_pkg::HEADER_BYTE);
      queue_item(sspr_pkg::CMD_BYTE, 8'h34);
      queue_item(sspr_pkg::CMD_BYTE, 8'h13);
      // re-arm in the middle of a packet, then a good one-parameter packet
      queue_item(sspr_pkg::CMD_ARM, 8'h00);
      queue_item(sspr_pkg::CMD_BYTE, sspr_pkg::HEADER_BYTE);
      queue_item(sspr_pkg::CMD_BYTE, sspr_pkg::HEADER_BYTE);
      queue_item(sspr_pkg::CMD_BYTE, 8'h55);
      queue_item(sspr_pkg::CMD_ARM, 8'h00);
      queue_item(sspr_pkg::CMD_BYTE, sspr_pkg::HEADER_BYTE);
      queue_item(sspr_pkg::CMD_BYTE, sspr_pkg::HEADER_BYTE);
      queue_item(sspr_pkg::CMD_BYTE, 8'h55);
      queue_item(sspr_pkg::CMD_BYTE, 8'h03);
      queue_item(sspr_pkg::CMD_BYTE, 8'h80);
      queue_item(sspr_pkg::CMD_BYTE, 8'hAA);
      queue_item(sspr_pkg::CMD_BYTE, 8'h7D);
      // timeout at the reset limit
      queue_item(sspr_pkg::CMD_ARM, 8'h00);
      repeat (int'(sspr_pkg::TIMEOUT_RESET)) queue_item(sspr_pkg::CMD_TICK, 8'h00);
      wait_until_drained();

      // random packets under a series of timeout settings
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_timeout(timeout_for_phase(p));
         phase_start = item_total;
         while (item_total - phase_start < ITEMS_PER_PHASE)
            queue_packet();
         // long receiver hold-off while the sender keeps offering
         if (p == 2) begin
            @(posedge clock);
            hold_request <= 1'b1;
         end
         wait_until_drained();
      end

      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

### filelist.f
rtl/sspr_pkg.sv
rtl/sspr_parser.sv
rtl/servo_status_packet_receiver_core.sv
bench/tb_servo_status_packet_receiver_core.sv
